>>> src/tpfc_pkg.sv
package tpfc_pkg;

	localparam int PALETTE_ENTRIES_DEF = 256;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	localparam int PADDR_W = 5;

	// source format codes
	localparam logic [2:0] FMT_PAL8     = 3'd0;
	localparam logic [2:0] FMT_ARGB4444 = 3'd1;
	localparam logic [2:0] FMT_ARGB1555 = 3'd2;
	localparam logic [2:0] FMT_RGB565K  = 3'd3;
	localparam logic [2:0] FMT_PASS     = 3'd4;

	// register indexes (paddr[4:2])
	localparam logic [2:0] REG_SOURCE_FORMAT   = 3'd0;
	localparam logic [2:0] REG_KEY_ENABLE      = 3'd1;
	localparam logic [2:0] REG_KEY_LOW         = 3'd2;
	localparam logic [2:0] REG_KEY_HIGH        = 3'd3;
	localparam logic [2:0] REG_PALETTE_PRESENT = 3'd4;

	// request types
	localparam logic REQ_TEXEL   = 1'b0;
	localparam logic REQ_PAL_WR  = 1'b1;

	typedef struct packed {
		logic [2:0]  source_format;
		logic        key_enable;
		logic [15:0] key_low;
		logic [15:0] key_high;
		logic        palette_present;
	} cfg_t;

	// classified item as it sits in the queue
	typedef struct packed {
		logic        pal_wr;
		logic [31:0] pixel;
		logic        eos;
		logic        hit;
		logic [7:0]  pal_index;
		logic [23:0] rgb;
	} qent_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

>>> src/tpfc_front.sv
module tpfc_front (
	input  tpfc_pkg::cfg_t  cfg,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            req_type,
	input  logic [31:0]     pixel_in,
	input  logic            end_of_surface,
	input  logic [7:0]      pal_index,
	input  logic [7:0]      pal_red,
	input  logic [7:0]      pal_green,
	input  logic [7:0]      pal_blue,
	input  tpfc_pkg::q_stat_t q_stat,
	output logic            push,
	output tpfc_pkg::qent_t push_ent
);
	import tpfc_pkg::*;

	logic [15:0] key_val;
	logic        key_cmp;
	logic        hit;

	// value compared against the key range depends on format
	always_comb begin
		key_val = 16'h0000;
		key_cmp = 1'b0;
		unique case (cfg.source_format)
			FMT_PAL8: begin
				key_val = {8'h00, pixel_in[7:0]};
				key_cmp = 1'b1;
			end
			FMT_RGB565K: begin
				key_val = pixel_in[15:0];
				key_cmp = 1'b1;
			end
			default: begin
				key_val = 16'h0000;
				key_cmp = 1'b0;
			end
		endcase
	end

	assign hit = key_cmp && cfg.key_enable &&
		(key_val >= cfg.key_low) && (key_val <= cfg.key_high);

	assign in_stall = q_stat.full;
	assign push     = in_valid && !q_stat.full;

	always_comb begin
		push_ent.pal_wr    = (req_type == REQ_PAL_WR);
		push_ent.pixel     = pixel_in;
		push_ent.eos       = end_of_surface;
		push_ent.hit       = hit;
		push_ent.pal_index = pal_index;
		push_ent.rgb       = {pal_red, pal_green, pal_blue};
	end

endmodule

>>> src/tpfc_queue.sv
module tpfc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tpfc_pkg::qent_t   push_ent,
	input  logic              pop,
	output tpfc_pkg::qent_t   head_ent,
	output tpfc_pkg::q_stat_t q_stat
);
	import tpfc_pkg::*;

	qent_t                  ent_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0]   count_q;

	assign q_stat.full  = (count_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign head_ent     = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_ent;
		end
	end

endmodule

>>> src/tpfc_back.sv
module tpfc_back #(
	parameter int PALETTE_ENTRIES = tpfc_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tpfc_pkg::cfg_t    cfg,
	input  tpfc_pkg::qent_t   head_ent,
	input  tpfc_pkg::q_stat_t q_stat,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [31:0]       pixel_out,
	output logic              key_hit,
	output logic              last_out
);
	import tpfc_pkg::*;

	localparam int AW = $clog2(PALETTE_ENTRIES);

	logic [23:0] pal_mem [PALETTE_ENTRIES];

	logic        advance;
	logic        idx_ok;
	logic [7:0]  rd_idx;

	logic        valid_s1;
	logic [31:0] pixel_s1;
	logic        eos_s1;
	logic        hit_s1;
	logic        in_range_s1;
	logic [23:0] rgb_s1;

	logic        valid_s2;
	logic [31:0] pixel_s2;
	logic        hit_s2;
	logic        eos_s2;

	logic [31:0] result;
	logic [23:0] pal_rgb;
	logic [15:0] x16;

	assign advance = !valid_s2 || !out_stall;
	assign pop     = advance && !q_stat.empty;

	// texel index for reads, entry index for writes share one field choice
	assign rd_idx = head_ent.pal_wr ? head_ent.pal_index : head_ent.pixel[7:0];
	assign idx_ok = ({1'b0, rd_idx} < 9'(PALETTE_ENTRIES));

	always_ff @(posedge clk) begin
		if (pop && head_ent.pal_wr && idx_ok) begin
			pal_mem[rd_idx[AW-1:0]] <= head_ent.rgb;
		end
		if (pop && !head_ent.pal_wr) begin
			rgb_s1 <= pal_mem[rd_idx[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= pop && !head_ent.pal_wr;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !head_ent.pal_wr) begin
			pixel_s1    <= head_ent.pixel;
			eos_s1      <= head_ent.eos;
			hit_s1      <= head_ent.hit;
			in_range_s1 <= idx_ok;
		end
		if (advance && valid_s1) begin
			pixel_s2 <= result;
			hit_s2   <= hit_s1;
			eos_s2   <= eos_s1;
		end
	end

	assign x16     = pixel_s1[15:0];
	assign pal_rgb = in_range_s1 ? rgb_s1 : 24'h000000;

	always_comb begin
		unique case (cfg.source_format)
			FMT_PAL8: begin
				result = cfg.palette_present ?
					{pal_rgb, (hit_s1 ? 8'h00 : 8'hFF)} : 32'h0000_0000;
			end
			FMT_ARGB4444: begin
				result = {16'h0000, x16[11:0], x16[15:12]};
			end
			FMT_ARGB1555: begin
				result = {16'h0000, x16[14:0], x16[15]};
			end
			FMT_RGB565K: begin
				result = {16'h0000, x16[15:6], x16[4:0], !hit_s1};
			end
			default: begin
				result = pixel_s1;
			end
		endcase
	end

	assign out_valid = valid_s2;
	assign pixel_out = pixel_s2;
	assign key_hit   = hit_s2;
	assign last_out  = eos_s2;

endmodule

>>> src/texture_pixel_format_converter.sv
// channel  | handshake                  | payload
// ---------+----------------------------+------------------------------------------
// input    | in_valid / in_stall        | req_type pixel_in end_of_surface pal_*
// output   | out_valid / out_stall      | pixel_out key_hit last_out
// config   | psel penable pwrite pready | paddr pwdata prdata
//
// One item per clock sustained while out_stall is low. A texel goes into the
// queue at its transfer edge, then the palette RAM read stage and the output register.
// Palette writes go through the same queue in order, are written to the RAM when popped, and give no result.
// Reset clears config to defaults and empties queue and pipeline; the
// palette RAM is not cleared. out_stall holds the output register and the
// RAM stage; the 4-entry queue then fills and raises in_stall.
module texture_pixel_format_converter #(
	parameter int PALETTE_ENTRIES = tpfc_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         req_type,
	input  logic [31:0]                  pixel_in,
	input  logic                         end_of_surface,
	input  logic [7:0]                   pal_index,
	input  logic [7:0]                   pal_red,
	input  logic [7:0]                   pal_green,
	input  logic [7:0]                   pal_blue,
	// output channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [31:0]                  pixel_out,
	output logic                         key_hit,
	output logic                         last_out,
	// config port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tpfc_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import tpfc_pkg::*;

	cfg_t    cfg_q;
	logic    cfg_wr;
	logic [2:0] reg_idx;

	q_stat_t q_stat;
	logic    push;
	logic    pop;
	qent_t   push_ent;
	qent_t   head_ent;

	// config registers: written on the access cycle of an APB write
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_format   <= FMT_PASS;
			cfg_q.key_enable      <= 1'b0;
			cfg_q.key_low         <= 16'h0000;
			cfg_q.key_high        <= 16'h0000;
			cfg_q.palette_present <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_SOURCE_FORMAT:   cfg_q.source_format   <= pwdata[2:0];
				REG_KEY_ENABLE:      cfg_q.key_enable      <= pwdata[0];
				REG_KEY_LOW:         cfg_q.key_low         <= pwdata[15:0];
				REG_KEY_HIGH:        cfg_q.key_high        <= pwdata[15:0];
				REG_PALETTE_PRESENT: cfg_q.palette_present <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SOURCE_FORMAT:   prdata = {29'h0, cfg_q.source_format};
			REG_KEY_ENABLE:      prdata = {31'h0, cfg_q.key_enable};
			REG_KEY_LOW:         prdata = {16'h0, cfg_q.key_low};
			REG_KEY_HIGH:        prdata = {16'h0, cfg_q.key_high};
			REG_PALETTE_PRESENT: prdata = {31'h0, cfg_q.palette_present};
			default:             prdata = 32'h0;
		endcase
	end

	// front: key compare and classification, straight into the queue
	tpfc_front u_front (
		.cfg            (cfg_q),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.pixel_in       (pixel_in),
		.end_of_surface (end_of_surface),
		.pal_index      (pal_index),
		.pal_red        (pal_red),
		.pal_green      (pal_green),
		.pal_blue       (pal_blue),
		.q_stat         (q_stat),
		.push           (push),
		.push_ent       (push_ent)
	);

	tpfc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.pop      (pop),
		.head_ent (head_ent),
		.q_stat   (q_stat)
	);

	// back: palette RAM access and format conversion
	tpfc_back #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head_ent  (head_ent),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pixel_out (pixel_out),
		.key_hit   (key_hit),
		.last_out  (last_out)
	);

endmodule

>>> tb/tpfc_texel_checker.sv
module tpfc_texel_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	// input channel
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic                         req_type,
	input  logic [31:0]                  pixel_in,
	input  logic                         end_of_surface,
	input  logic [7:0]                   pal_index,
	input  logic [7:0]                   pal_red,
	input  logic [7:0]                   pal_green,
	input  logic [7:0]                   pal_blue,
	// output channel
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [31:0]                  pixel_out,
	input  logic                         key_hit,
	input  logic                         last_out,
	// config port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [tpfc_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	// to the top
	output int                           mismatch_count,
	output int                           texels_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import tpfc_pkg::*;

	typedef struct packed {
		logic [31:0] pixel;
		logic        hit;
		logic        last;
	} texel_res_t;

	cfg_t        cfg;
	logic [23:0] palette [0:PALETTE_ENTRIES_DEF-1] = '{default: '0};
	texel_res_t  texel_queue [$];
	int          fails = 0;

	function automatic logic in_key(input logic [15:0] v);
		return cfg.key_enable && (v >= cfg.key_low) && (v <= cfg.key_high);
	endfunction

	function automatic texel_res_t convert_texel(input logic [31:0] pix, input logic eos);
		texel_res_t r;
		logic [15:0] x;
		logic [7:0]  idx;
		x = pix[15:0];
		idx = pix[7:0];
		r.pixel = '0;
		r.hit = 1'b0;
		r.last = eos;
		case (cfg.source_format)
			FMT_PAL8: begin
				r.hit = in_key({8'h00, idx});
				if (cfg.palette_present)
					r.pixel = {palette[idx], r.hit ? 8'h00 : 8'hFF};
			end
			FMT_ARGB4444: r.pixel = {16'h0000, x[11:0], x[15:12]};
			FMT_ARGB1555: r.pixel = {16'h0000, x[14:0], x[15]};
			FMT_RGB565K: begin
				r.hit = in_key(x);
				r.pixel = {16'h0000, x[15:6], x[4:0], ~r.hit};
			end
			default: r.pixel = pix;  // passthrough, unused codes too
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		texel_res_t want;
		if (!arst_n) begin
			cfg.source_format = FMT_PASS;
			cfg.key_enable = 1'b0;
			cfg.key_low = '0;
			cfg.key_high = '0;
			cfg.palette_present = 1'b0;
			texel_queue.delete();
		end else begin
			// result side first: a transfer never leaves on the edge it came in
			if (out_valid && !out_stall) begin
				if (texel_queue.size() == 0) begin
					if (fails < 10)
						$display("unexpected result: pixel_out %h key_hit %b last_out %b",
							pixel_out, key_hit, last_out);
					fails++;
				end else begin
					want = texel_queue.pop_front();
					if (pixel_out !== want.pixel || key_hit !== want.hit ||
							last_out !== want.last) begin
						if (fails < 10)
							$display("mismatch: pixel_out %h/%h key_hit %b/%b last_out %b/%b (exp/act)",
								want.pixel, pixel_out, want.hit, key_hit, want.last, last_out);
						fails++;
					end
				end
			end

			if (in_valid && !in_stall) begin
				if (req_type == REQ_PAL_WR)
					palette[pal_index] = {pal_red, pal_green, pal_blue};
				else
					texel_queue.push_back(convert_texel(pixel_in, end_of_surface));
			end

			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_SOURCE_FORMAT:   cfg.source_format = pwdata[2:0];
					REG_KEY_ENABLE:      cfg.key_enable = pwdata[0];
					REG_KEY_LOW:         cfg.key_low = pwdata[15:0];
					REG_KEY_HIGH:        cfg.key_high = pwdata[15:0];
					REG_PALETTE_PRESENT: cfg.palette_present = pwdata[0];
					default: ;
				endcase
			end
		end
		texels_pending <= texel_queue.size();
		mismatch_count <= fails;
	end

endmodule

>>> tb/tb_texture_pixel_format_converter.sv
module tb_texture_pixel_format_converter;
	timeunit 1ns;
	timeprecision 1ps;

	import tpfc_pkg::*;

	// generous: well above the slowest correct run
	localparam int CYCLE_LIMIT = 300000;
	// texel path is three deep; palette writes give no result, so
	// allow the pipe to empty before touching registers
	localparam int DRAIN_CYCLES = 12;
	localparam int RAND_PHASES = 16;
	localparam int PHASE_ITEMS = 7;
	localparam logic [2:0] FMT_UNUSED_TOP = 3'd7;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                req_type;
	logic [31:0]         pixel_in;
	logic                end_of_surface;
	logic [7:0]          pal_index;
	logic [7:0]          pal_red;
	logic [7:0]          pal_green;
	logic [7:0]          pal_blue;
	logic                out_valid;
	logic                out_stall;
	logic [31:0]         pixel_out;
	logic                key_hit;
	logic                last_out;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	int                  mismatch_count;
	int                  texels_pending;
	int                  cycles = 0;
	bit                  idle_on;

	texture_pixel_format_converter uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.pixel_in       (pixel_in),
		.end_of_surface (end_of_surface),
		.pal_index      (pal_index),
		.pal_red        (pal_red),
		.pal_green      (pal_green),
		.pal_blue       (pal_blue),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pixel_out      (pixel_out),
		.key_hit        (key_hit),
		.last_out       (last_out),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	tpfc_texel_checker texel_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.pixel_in       (pixel_in),
		.end_of_surface (end_of_surface),
		.pal_index      (pal_index),
		.pal_red        (pal_red),
		.pal_green      (pal_green),
		.pal_blue       (pal_blue),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pixel_out      (pixel_out),
		.key_hit        (key_hit),
		.last_out       (last_out),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.mismatch_count (mismatch_count),
		.texels_pending (texels_pending)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// watchdog: a hang or a lost result ends here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// result side back-pressure, raised with a 23 percent chance when idling is on
	always @(posedge clk) begin
		out_stall <= idle_on && ($urandom_range(99) < 23);
	end

	// One input transfer. Idle cycles ahead of it carry junk payload with
	// valid low; once raised, valid and payload hold until the transfer.
	task automatic push_item(input logic req, input logic [31:0] pix, input logic eos,
			input logic [7:0] idx, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		while (idle_on && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			pixel_in <= $urandom;
			pal_index <= 8'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		pixel_in <= pix;
		end_of_surface <= eos;
		pal_index <= idx;
		pal_red <= r;
		pal_green <= g;
		pal_blue <= b;
		do @(posedge clk); while (in_stall);
	endtask

	// texel: palette fields are don't-care
	task automatic push_texel(input logic [31:0] pix, input logic eos);
		push_item(REQ_TEXEL, pix, eos, 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom));
	endtask

	// palette write: pixel and end flag are ignored by the block
	task automatic push_pal(input logic [7:0] idx, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b);
		push_item(REQ_PAL_WR, $urandom, 1'($urandom_range(1)), idx, r, g, b);
	endtask

	// stop feeding, let every result come out, then let the pipe go quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (texels_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// setup + access, write lands on the access edge (pready tied high)
	task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Only called with the block idle. Upper data bits get junk, the
	// registers must keep just their own width.
	task automatic configure(input logic [2:0] fmt, input logic ken, input logic [15:0] klo,
			input logic [15:0] khi, input logic pal_on);
		logic [31:0] junk;
		junk = $urandom;
		apb_write(REG_SOURCE_FORMAT, {junk[31:3], fmt});
		apb_write(REG_KEY_ENABLE, {junk[30:0], ken});
		apb_write(REG_KEY_LOW, {junk[15:0], klo});
		apb_write(REG_KEY_HIGH, {junk[23:8], khi});
		apb_write(REG_PALETTE_PRESENT, {junk[31:1], pal_on});
	endtask

	initial begin
		int lo;
		int hi;
		int top;
		logic [2:0] fmt;
		logic [31:0] pix;

		idle_on = 1'b1;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		req_type <= REQ_TEXEL;
		pixel_in <= '0;
		end_of_surface <= 1'b0;
		pal_index <= '0;
		pal_red <= '0;
		pal_green <= '0;
		pal_blue <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Load every palette entry before any texel, so no lookup ever hits
		// an entry that was never written. Extremes at both ends.
		for (int i = 0; i < PALETTE_ENTRIES_DEF; i++) begin
			if (i == 0)
				push_pal(8'h00, 8'h00, 8'h00, 8'h00);
			else if (i == PALETTE_ENTRIES_DEF - 1)
				push_pal(8'hFF, 8'hFF, 8'hFF, 8'hFF);
			else
				push_pal(i[7:0], 8'($urandom), 8'($urandom), 8'($urandom));
		end

		// --- directed part ---
		// reset defaults: passthrough
		push_texel(32'h0000_0000, 1'b0);
		push_texel(32'hFFFF_FFFF, 1'b1);

		// paletted with no palette: zero out, key compare still reported
		settle();
		configure(FMT_PAL8, 1'b1, 16'h0000, 16'h00FF, 1'b0);
		push_texel(32'h0000_0000, 1'b0);
		push_texel(32'h0000_00FF, 1'b1);

		// paletted, key range edges
		settle();
		configure(FMT_PAL8, 1'b1, 16'h0010, 16'h0020, 1'b1);
		push_texel(32'h0000_000F, 1'b0);
		push_texel(32'h0000_0010, 1'b0);
		push_texel(32'h0000_0020, 1'b0);
		push_texel(32'h0000_0021, 1'b1);
		push_texel(32'hFFFF_FF00, 1'b0);
		push_texel(32'h0000_00FF, 1'b0);

		// empty key range; then a lookup right behind a write to its entry
		settle();
		configure(FMT_PAL8, 1'b1, 16'h0030, 16'h0020, 1'b1);
		push_texel(32'h0000_0025, 1'b0);
		push_pal(8'h42, 8'hAA, 8'h55, 8'hC3);
		push_texel(32'h1234_5642, 1'b1);

		settle();
		configure(FMT_ARGB4444, 1'b0, 16'h0000, 16'h0000, 1'b0);
		push_texel(32'h0000_0000, 1'b0);
		push_texel(32'h0000_FFFF, 1'b0);
		push_texel(32'h0000_F000, 1'b0);
		push_texel(32'h0000_000F, 1'b1);
		push_texel(32'hABCD_1234, 1'b0);

		settle();
		configure(FMT_ARGB1555, 1'b1, 16'h0000, 16'hFFFF, 1'b1);
		push_texel(32'h0000_8000, 1'b0);
		push_texel(32'h0000_7FFF, 1'b0);
		push_texel(32'hFFFF_FFFF, 1'b1);

		// single-value key range for 565
		settle();
		configure(FMT_RGB565K, 1'b1, 16'h1234, 16'h1234, 1'b0);
		push_texel(32'h0000_1234, 1'b0);
		push_texel(32'h0000_1235, 1'b0);
		push_texel(32'hFFFF_FFFF, 1'b1);

		// key disabled: same value must not hit
		settle();
		configure(FMT_RGB565K, 1'b0, 16'h1234, 16'h1234, 1'b0);
		push_texel(32'h0000_1234, 1'b0);

		// unused format code behaves as passthrough
		settle();
		configure(FMT_UNUSED_TOP, 1'b1, 16'h0000, 16'hFFFF, 1'b1);
		push_texel(32'hDEAD_BEEF, 1'b1);

		// --- random part ---
		// Each phase: fresh settings, then a burst of texels with some
		// palette rewrites mixed in. Phases 6..8 run with no idling.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			settle();
			idle_on = (ph < 6) || (ph > 8);
			fmt = ph[2:0];
			top = (fmt == FMT_PAL8) ? 255 : 16'hFFFF;
			lo = $urandom_range(top);
			hi = lo + $urandom_range(64);
			if (hi > top)
				hi = top;
			if ($urandom_range(5) == 0 && lo > 0)
				hi = lo - 1;  // empty range
			if (ph == 3 || ph == 10) begin
				lo = 0;
				hi = 16'hFFFF;
			end else if (ph == 11) begin
				lo = 16'hFFFF;
				hi = 16'hFFFF;
			end else if (ph == 8) begin
				lo = 0;
				hi = 0;
			end
			configure(fmt, (ph % 5) != 4, lo[15:0], hi[15:0], (ph % 4) != 1);

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(99) < 15) begin
					push_pal(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
				end else begin
					pix = $urandom;
					// steer about half the texels into the key range
					if (lo <= hi && $urandom_range(1) == 1) begin
						if (fmt == FMT_PAL8 && lo <= 255)
							pix[7:0] = 8'($urandom_range((hi > 255) ? 255 : hi, lo));
						else if (fmt != FMT_PAL8)
							pix[15:0] = 16'($urandom_range(hi, lo));
					end
					push_texel(pix, $urandom_range(7) == 0);
				end
			end
		end

		settle();
		idle_on = 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && texels_pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> filelist.f
src/tpfc_pkg.sv
src/tpfc_front.sv
src/tpfc_queue.sv
src/tpfc_back.sv
src/texture_pixel_format_converter.sv
tb/tpfc_texel_checker.sv
tb/tb_texture_pixel_format_converter.sv
